// ----- rtl/core/swhc_pkg.sv -----
package swhc_pkg;

	localparam int WINDOW  = 300;
	localparam int TIME_W  = 31;
	localparam int COUNT_W = 32;
	localparam int SUM_W   = 41;
	localparam int SLOT_W  = $clog2(WINDOW);
	// remainder before the final correction stays below twice the window
	localparam int REM_W   = $clog2(2 * WINDOW);
	localparam int SHIFT   = TIME_W + $clog2(WINDOW);
	localparam logic [31:0] RECIP = 32'((64'd1 << SHIFT) / WINDOW);

	localparam logic       KIND_HIT   = 1'b0;
	localparam logic       KIND_QUERY = 1'b1;

	typedef logic [SLOT_W-1:0]  slot_t;
	typedef logic [TIME_W-1:0]  time_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [SUM_W-1:0]   sum_t;

	// broadcast to every cell: hit write and scan cutoff
	typedef struct packed {
		logic               hit_en;
		slot_t              hit_slot;
		time_t              hit_tag;
		logic signed [31:0] cutoff;
	} cell_ctl_t;

	// partial sum handed from cell to cell
	typedef struct packed {
		logic vld;
		sum_t sum;
	} tok_t;

endpackage

// ----- rtl/core/swhc_slot.sv -----
module swhc_slot (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  swhc_pkg::time_t event_time,
	output logic            done,
	output swhc_pkg::slot_t slot,
	output swhc_pkg::time_t tag
);
	import swhc_pkg::*;

	localparam int PROD_W = TIME_W + 32;
	localparam int QW_W   = TIME_W + $clog2(WINDOW + 1);

	logic [PROD_W-1:0] prod;
	logic [QW_W-1:0]   qw;
	logic              vld_s1, vld_s2, vld_s3;
	time_t             tag_s1, tag_s2, tag_s3;
	time_t             quo_s1;
	logic [REM_W-1:0]  rem_s2;
	slot_t             slot_s3;

	// quotient estimate by reciprocal, at most one short
	assign prod = PROD_W'(event_time) * PROD_W'(RECIP);
	assign qw   = QW_W'(quo_s1) * QW_W'(WINDOW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1 <= event_time;
		quo_s1 <= TIME_W'(prod >> SHIFT);
		tag_s2 <= tag_s1;
		rem_s2 <= REM_W'(QW_W'(tag_s1) - qw);
		tag_s3 <= tag_s2;
		if (rem_s2 >= REM_W'(WINDOW)) begin
			slot_s3 <= SLOT_W'(rem_s2 - REM_W'(WINDOW));
		end else begin
			slot_s3 <= SLOT_W'(rem_s2);
		end
	end

	assign done = vld_s3;
	assign slot = slot_s3;
	assign tag  = tag_s3;

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> (32'(slot_s3) < 32'(WINDOW)))
		else $error("slot out of range");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> (32'(rem_s2) < 32'(2 * WINDOW)))
		else $error("remainder estimate too far off");

	a_tag_carried: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> (tag_s3 == $past(event_time, 3)))
		else $error("tag lost in slot pipeline");

endmodule

// ----- rtl/core/swhc_cell.sv -----
module swhc_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  swhc_pkg::slot_t     index,
	input  swhc_pkg::cell_ctl_t ctl,
	input  swhc_pkg::tok_t      tok_in,
	output swhc_pkg::tok_t      tok_out
);
	import swhc_pkg::*;

	time_t          tag_q;
	count_t         count_q;
	logic           tok_vld_q;
	sum_t           sum_q;
	logic           in_window;
	logic [SUM_W:0] sum_ext;

	assign in_window = $signed({1'b0, tag_q}) > ctl.cutoff;
	assign sum_ext   = {1'b0, tok_in.sum}
	                 + (in_window ? (SUM_W+1)'(count_q) : (SUM_W+1)'(0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q     <= '0;
			count_q   <= '0;
			tok_vld_q <= 1'b0;
		end else begin
			tok_vld_q <= tok_in.vld;
			if (ctl.hit_en && ctl.hit_slot == index) begin
				if (tag_q == ctl.hit_tag) begin
					if (count_q != '1) begin
						count_q <= count_q + 1'b1;
					end
				end else begin
					tag_q   <= ctl.hit_tag;
					count_q <= COUNT_W'(1);
				end
			end
		end
	end

	// saturating partial sum
	always_ff @(posedge clk) begin
		if (tok_in.vld) begin
			sum_q <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
		end
	end

	assign tok_out.vld = tok_vld_q;
	assign tok_out.sum = sum_q;

endmodule

// ----- rtl/core/sliding_window_hit_counter_top.sv -----
// sliding window hit counter
// input channel: in_valid / in_stall with kind and event_time. kind 0 records
// one hit at event_time, kind 1 asks for the hits whose bucket tag is later
// than event_time minus the window.
// output channel: out_valid / out_stall with hits_in_window, one word per
// query, none per hit.
// a hit runs through a three-stage remainder unit and writes its cell
// before the next word is accepted.
// a query sends a partial sum down the row of WINDOW cells, one cell per
// cycle; no further word is taken until the result is registered in the
// output register.
// the output register lets a hit be taken while a result waits; a further
// query is held off until the waiting result has been taken.
// a stalled result holds its value until it is taken.
// reset clears every bucket tag and count at once, empties the output
// register and returns the block to idle; no clearing pass is needed.
module sliding_window_hit_counter_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic            kind,
	input  swhc_pkg::time_t event_time,
	output logic            out_valid,
	input  logic            out_stall,
	output swhc_pkg::sum_t  hits_in_window
);
	import swhc_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_HIT, ST_SCAN} state_t;

	state_t             state_q;
	logic               inject_q;
	logic               out_valid_q;
	sum_t               out_sum_q;
	logic signed [31:0] cutoff_q;
	logic               accept;
	logic               slot_done;
	slot_t              slot;
	time_t              slot_tag;
	cell_ctl_t          ctl;
	tok_t               chain [WINDOW+1];
	logic [WINDOW-1:0]  tok_vld;

	assign in_stall = (state_q != ST_IDLE) || (kind == KIND_QUERY && out_valid_q);
	assign accept   = in_valid && !in_stall;

	swhc_slot u_slot (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (accept && kind == KIND_HIT),
		.event_time (event_time),
		.done       (slot_done),
		.slot       (slot),
		.tag        (slot_tag)
	);

	assign ctl.hit_en   = slot_done;
	assign ctl.hit_slot = slot;
	assign ctl.hit_tag  = slot_tag;
	assign ctl.cutoff   = cutoff_q;

	assign chain[0].vld = inject_q;
	assign chain[0].sum = '0;

	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		swhc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.index   (SLOT_W'(i)),
			.ctl     (ctl),
			.tok_in  (chain[i]),
			.tok_out (chain[i+1])
		);
		assign tok_vld[i] = chain[i+1].vld;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			inject_q    <= 1'b0;
			out_valid_q <= 1'b0;
			out_sum_q   <= '0;
		end else begin
			inject_q <= accept && kind == KIND_QUERY;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (kind == KIND_QUERY) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_HIT;
						end
					end
				end
				ST_HIT: begin
					if (slot_done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (chain[WINDOW].vld) begin
						out_valid_q <= 1'b1;
						out_sum_q   <= chain[WINDOW].sum;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && kind == KIND_QUERY) begin
			cutoff_q <= $signed({1'b0, event_time}) - 32'sd0 - 32'(WINDOW);
		end
	end

	assign out_valid      = out_valid_q;
	assign hits_in_window = out_sum_q;

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vld))
		else $error("more than one partial sum in the row");

	a_no_hit_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		slot_done |-> (state_q == ST_HIT && tok_vld == '0))
		else $error("bucket write during a scan");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (tok_vld == '0 && !inject_q))
		else $error("partial sum left in the row while idle");

	a_result_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		chain[WINDOW].vld |-> !out_valid_q)
		else $error("result arrives while output register is full");

endmodule

// ----- tb/sv/swhc_window_checker.sv -----
`timescale 1ns / 1ps

module swhc_window_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_stall,
	input  logic            kind,
	input  swhc_pkg::time_t event_time,
	input  logic            out_valid,
	input  logic            out_stall,
	input  swhc_pkg::sum_t  hits_in_window,
	output int              fail_count,
	output int              sums_owed
);
	import swhc_pkg::*;

	localparam longint unsigned SUM_LIMIT = (64'd1 << SUM_W) - 64'd1;

	time_t  tag_store   [WINDOW];
	count_t count_store [WINDOW];
	sum_t   owed_totals [$];

	initial begin
		fail_count = 0;
		sums_owed  = 0;
	end

	// hits in buckets whose tag is later than the cutoff, which may be negative
	function automatic sum_t window_total(input time_t t);
		longint          cutoff;
		longint unsigned acc;
		cutoff = longint'(t) - longint'(WINDOW);
		acc    = 0;
		for (int i = 0; i < WINDOW; i++) begin
			if (longint'(tag_store[i]) > cutoff) begin
				acc += longint'(count_store[i]);
				if (acc > SUM_LIMIT)
					acc = SUM_LIMIT;
			end
		end
		return sum_t'(acc);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int unsigned slot;
		sum_t        due;
		if (!arst_n) begin
			foreach (tag_store[i]) begin
				tag_store[i]   = '0;
				count_store[i] = '0;
			end
			owed_totals.delete();
			sums_owed = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (owed_totals.size() == 0) begin
					$error("hits_in_window: expected no word, actual %0d", hits_in_window);
					fail_count++;
				end else begin
					due = owed_totals.pop_front();
					if (hits_in_window !== due) begin
						$error("hits_in_window: expected %0d, actual %0d", due, hits_in_window);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (kind == KIND_QUERY) begin
					owed_totals.push_back(window_total(event_time));
				end else begin
					slot = event_time % WINDOW;
					if (tag_store[slot] == event_time) begin
						if (count_store[slot] != '1)
							count_store[slot] = count_store[slot] + 1'b1;
					end else begin
						// a differing tag always replaces the bucket, older or not
						tag_store[slot]   = event_time;
						count_store[slot] = 1;
					end
				end
			end
			sums_owed = owed_totals.size();
		end
	end

endmodule

// ----- tb/sv/tb_sliding_window_hit_counter_top.sv -----
`timescale 1ns / 1ps

module tb_sliding_window_hit_counter_top;
	import swhc_pkg::*;

	localparam time_t LAST_SECOND = '1;
	localparam int    RANDOM_WORDS = 575;
	localparam int    HOLD_CYCLES  = 1200;

	logic  clk;
	logic  arst_n;
	logic  in_valid;
	logic  in_stall;
	logic  kind;
	time_t event_time;
	logic  out_valid;
	logic  out_stall;
	sum_t  hits_in_window;
	int    fail_count;
	int    sums_owed;

	bit    gaps_on  = 1'b1;
	bit    hold_out = 1'b0;

	sliding_window_hit_counter_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.kind           (kind),
		.event_time     (event_time),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.hits_in_window (hits_in_window)
	);

	swhc_window_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.kind           (kind),
		.event_time     (event_time),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.hits_in_window (hits_in_window),
		.fail_count     (fail_count),
		.sums_owed      (sums_owed)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		#10ms;
		$display("tb_sliding_window_hit_counter_top: errors");
		$finish;
	end

	task automatic send_word(input logic k, input time_t t);
		in_valid   <= 1'b1;
		kind       <= k;
		event_time <= t;
		do @(posedge clk); while (in_stall);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	// receiver: one long hold on request, otherwise random stall bursts
	initial begin
		out_stall = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_out) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_out = 1'b0;
				out_stall <= 1'b0;
			end else if (gaps_on && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		time_t now;
		int    roll;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		kind       = KIND_HIT;
		event_time = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty store, then a hit on the cleared tag of bucket zero
		send_word(KIND_QUERY, time_t'(0));
		send_word(KIND_HIT, time_t'(0));
		send_word(KIND_HIT, time_t'(0));
		send_word(KIND_QUERY, time_t'(0));
		send_word(KIND_HIT, time_t'(WINDOW - 1));
		send_word(KIND_QUERY, time_t'(WINDOW - 1));
		send_word(KIND_HIT, time_t'(WINDOW));
		send_word(KIND_QUERY, time_t'(WINDOW));
		// top of the time range, then tags ahead of an early query
		send_word(KIND_HIT, LAST_SECOND);
		send_word(KIND_HIT, LAST_SECOND);
		send_word(KIND_QUERY, LAST_SECOND);
		send_word(KIND_QUERY, time_t'(250));
		// an older hit still overwrites its bucket
		send_word(KIND_HIT, time_t'(LAST_SECOND - WINDOW));
		send_word(KIND_QUERY, LAST_SECOND);
		// window edge: a tag equal to the cutoff drops out
		send_word(KIND_HIT, time_t'(1000));
		send_word(KIND_HIT, time_t'(1000));
		send_word(KIND_HIT, time_t'(1000 + WINDOW - 1));
		send_word(KIND_QUERY, time_t'(1000 + WINDOW - 1));
		send_word(KIND_QUERY, time_t'(1000 + WINDOW));
		send_word(KIND_QUERY, time_t'(1000 + 2 * WINDOW - 1));
		send_word(KIND_HIT, 31'h2AAA_AAAA);
		send_word(KIND_HIT, 31'h5555_5555);
		send_word(KIND_QUERY, 31'h5555_5555);
		send_word(KIND_QUERY, 31'h2AAA_AAAA);

		now = time_t'($urandom_range(0, 5000));
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n == 100)
				gaps_on = 1'b0;
			if (n == 150)
				gaps_on = 1'b1;
			if (n == 250)
				hold_out = 1'b1;
			if (n == RANDOM_WORDS - 60)
				gaps_on = 1'b0;

			roll = $urandom_range(0, 99);
			if (roll < 3)
				now = time_t'($urandom());
			else if (roll < 8)
				now = time_t'(now + $urandom_range(WINDOW / 2, 2 * WINDOW));
			else if (roll < 40)
				now = time_t'(now + 1);

			roll = $urandom_range(0, 99);
			if (n >= 250 && n < 262) begin
				// keep offering words while the output is held
				if (n % 3 == 0)
					send_word(KIND_QUERY, now);
				else
					send_word(KIND_HIT, time_t'(now - $urandom_range(0, 4)));
			end else if (roll < 5) begin
				send_word(logic'($urandom_range(0, 1)), time_t'($urandom()));
			end else if (roll < 72) begin
				send_word(KIND_HIT, time_t'(now - $urandom_range(0, 4)));
			end else begin
				send_word(KIND_QUERY,
					time_t'(now + $urandom_range(0, WINDOW) - WINDOW / 2));
			end
		end
		in_valid <= 1'b0;

		while (sums_owed != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && sums_owed == 0)
			$display("tb_sliding_window_hit_counter_top: clean");
		else
			$display("tb_sliding_window_hit_counter_top: errors");
		$finish;
	end

endmodule
